@@ sv/spba_pkg.sv @@
// shared types, constants and register codes of the scaled padded blit address generator
package spba_pkg;

  localparam int unsigned MAX_EXTENT = 4096;
  localparam int unsigned MAX_PAD    = 255;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned SRC_W   = 15;
  localparam int unsigned FRAME_W = 13;
  localparam int unsigned PAD_W   = 8;
  localparam int unsigned ATLAS_W = 15;
  localparam int unsigned DEST_W  = 14;
  localparam int unsigned INDEX_W = 28;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned REGIDX_W = 3;

  // interior coordinate is below MAX_EXTENT, quotient below 2^SRC_W
  localparam int unsigned INNER_W = $clog2(MAX_EXTENT);
  localparam int unsigned REM_W   = INNER_W;
  localparam int unsigned QUO_W   = SRC_W;
  localparam int unsigned PROD_W  = INNER_W + SRC_W;
  localparam int unsigned SUM_W   = 15;

  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  typedef enum logic [REGIDX_W-1:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_PAD          = 3'd4,
    REG_PITCH        = 3'd5,
    REG_DEST_X       = 3'd6,
    REG_DEST_Y       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] source_index;
    logic [INDEX_W-1:0] atlas_index;
    logic               outside;
  } out_t;

  typedef struct packed {
    logic [SRC_W-1:0]   src_width;
    logic [SRC_W-1:0]   src_height;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
    logic [PAD_W-1:0]   pad;
    logic [ATLAS_W-1:0] pitch;
    logic [DEST_W-1:0]  dest_x;
    logic [DEST_W-1:0]  dest_y;
  } cfg_t;

  // one axis of the divider: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] lo;
  } div_lane_t;

  typedef struct packed {
    logic               valid;
    logic               outside;
    logic [INDEX_W-1:0] atlas_index;
    div_lane_t          x;
    div_lane_t          y;
  } cell_t;

endpackage

@@ sv/spba_prep.sv @@
// front stages: clamp to the frame interior, scale products and atlas index
module spba_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  spba_pkg::in_t  in_data,
  input  spba_pkg::cfg_t cfg,
  output spba_pkg::cell_t dout
);
  import spba_pkg::*;

  typedef struct packed {
    logic               valid;
    logic               outside;
    logic [INNER_W-1:0] inner_x;
    logic [INNER_W-1:0] inner_y;
    logic [SUM_W-1:0]   ax;
    logic [SUM_W-1:0]   ay;
  } s1_t;

  s1_t   s1;
  s1_t   s1_next;
  cell_t s2;

  // remove padding offset and clamp into 0 .. frame-1
  function automatic logic [INNER_W-1:0] clamp_axis(
    input logic [COORD_W-1:0] c,
    input logic [PAD_W-1:0]   p,
    input logic [FRAME_W-1:0] f
  );
    logic [COORD_W-1:0] diff;
    logic [COORD_W-1:0] lim;
    logic [COORD_W-1:0] inner;
    diff  = c - COORD_W'(p);
    lim   = f - FRAME_W'(1);
    inner = (c < COORD_W'(p)) ? '0 : diff;
    if (inner > lim) begin
      inner = lim;
    end
    return inner[INNER_W-1:0];
  endfunction

  function automatic logic beyond(
    input logic [COORD_W-1:0] c,
    input logic [PAD_W-1:0]   p,
    input logic [FRAME_W-1:0] f
  );
    logic [COORD_W:0] span;
    span = {1'b0, f} + {{(COORD_W-PAD_W){1'b0}}, p, 1'b0};
    return (f == '0) || ({1'b0, c} >= span);
  endfunction

  always_comb begin
    s1_next.valid   = in_fire;
    s1_next.outside = beyond(in_data.column, cfg.pad, cfg.frame_width) ||
                      beyond(in_data.row, cfg.pad, cfg.frame_height);
    s1_next.inner_x = clamp_axis(in_data.column, cfg.pad, cfg.frame_width);
    s1_next.inner_y = clamp_axis(in_data.row, cfg.pad, cfg.frame_height);
    s1_next.ax      = SUM_W'(cfg.dest_x) + SUM_W'(in_data.column);
    s1_next.ay      = SUM_W'(cfg.dest_y) + SUM_W'(in_data.row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= s1_next;
    end
  end

  logic [PROD_W-1:0]      prod_x;
  logic [PROD_W-1:0]      prod_y;
  logic [2*SUM_W-1:0]     row_base;

  assign prod_x   = PROD_W'(s1.inner_x) * PROD_W'(cfg.src_width);
  assign prod_y   = PROD_W'(s1.inner_y) * PROD_W'(cfg.src_height);
  assign row_base = (2*SUM_W)'(s1.ay) * (2*SUM_W)'(cfg.pitch);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid       <= s1.valid;
      s2.outside     <= s1.outside;
      s2.atlas_index <= row_base[INDEX_W-1:0] + INDEX_W'(s1.ax);
      s2.x.rem       <= prod_x[PROD_W-1:QUO_W];
      s2.x.lo        <= prod_x[QUO_W-1:0];
      s2.y.rem       <= prod_y[PROD_W-1:QUO_W];
      s2.y.lo        <= prod_y[QUO_W-1:0];
    end
  end

  assign dout = s2;

endmodule

@@ sv/spba_cell.sv @@
// one restoring division step for both axes, registered toward the next cell
module spba_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [spba_pkg::FRAME_W-1:0] frame_w,
  input  logic [spba_pkg::FRAME_W-1:0] frame_h,
  input  spba_pkg::cell_t             din,
  output spba_pkg::cell_t             dout
);
  import spba_pkg::*;

  cell_t data;

  function automatic div_lane_t step(input div_lane_t l, input logic [FRAME_W-1:0] d);
    logic [REM_W:0] t;
    logic           ge;
    logic [REM_W:0] r;
    div_lane_t      res;
    t       = {l.rem, l.lo[QUO_W-1]};
    ge      = t >= (REM_W+1)'(d);
    r       = ge ? t - (REM_W+1)'(d) : t;
    res.rem = r[REM_W-1:0];
    res.lo  = {l.lo[QUO_W-2:0], ge};
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data.valid       <= din.valid;
      data.outside     <= din.outside;
      data.atlas_index <= din.atlas_index;
      data.x           <= step(din.x, frame_w);
      data.y           <= step(din.y, frame_h);
    end
  end

  assign dout = data;

endmodule

@@ sv/spba_fifo.sv @@
// result queue between the fixed-latency pipe and the output channel
module spba_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  spba_pkg::out_t wr_data,
  input  logic           rd_en,
  output spba_pkg::out_t rd_data,
  output logic           empty
);
  import spba_pkg::*;

  out_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             head_valid;
  logic             load;

  // refill the output register from storage when it is free or being drained
  assign load = (fill != '0) && (!head_valid || rd_en);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rd_data <= entries[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fill       <= '0;
      head_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (load) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + CNT_W'(wr_en) - CNT_W'(load);
      if (load) begin
        head_valid <= 1'b1;
      end else if (rd_en) begin
        head_valid <= 1'b0;
      end
    end
  end

  assign empty = !head_valid;

endmodule

@@ sv/scaled_padded_blit_address_top.sv @@
// top level of the scaled padded blit address generator
//
// takes one padded-frame coordinate (column, row) per transfer and returns the source
// pixel index, the atlas pixel index and an outside flag. the coordinate is clamped to
// the frame interior (edge replication of the border), scaled by nearest-neighbor
// division c*src/frame and turned into row-major indexes. one transfer per clock is
// sustained in both directions while out_ready stays high; each item passes two front
// stages, the 15-cell division chain (one quotient bit per cell), the final index stage
// and the result queue (storage write, then registered read). the queue holds up to 32
// results and a credit count keeps the input ready only while a queue slot is reserved
// for every item in flight, so output stalls never lose data. configuration writes go
// through cfg_we/cfg_index/cfg_data and must only happen while no items are in flight.
module scaled_padded_blit_address_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spba_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spba_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [spba_pkg::REGIDX_W-1:0] cfg_index,
  input  logic [spba_pkg::CFG_W-1:0]    cfg_data
);
  import spba_pkg::*;

  // configuration registers
  cfg_t cfg;
  cfg_t cfg_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width    <= SRC_W'(1);
      cfg.src_height   <= SRC_W'(1);
      cfg.frame_width  <= FRAME_W'(1);
      cfg.frame_height <= FRAME_W'(1);
      cfg.pad          <= '0;
      cfg.pitch        <= ATLAS_W'(64);
      cfg.dest_x       <= '0;
      cfg.dest_y       <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:    cfg.src_width    <= cfg_data[SRC_W-1:0];
        REG_SRC_HEIGHT:   cfg.src_height   <= cfg_data[SRC_W-1:0];
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[FRAME_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[FRAME_W-1:0];
        REG_PAD:          cfg.pad          <= cfg_data[PAD_W-1:0];
        REG_PITCH:        cfg.pitch        <= cfg_data[ATLAS_W-1:0];
        REG_DEST_X:       cfg.dest_x       <= cfg_data[DEST_W-1:0];
        REG_DEST_Y:       cfg.dest_y       <= cfg_data[DEST_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate frame size and border to the supported extents
  always_comb begin
    cfg_eff = cfg;
    if (cfg.frame_width > FRAME_W'(MAX_EXTENT)) begin
      cfg_eff.frame_width = FRAME_W'(MAX_EXTENT);
    end
    if (cfg.frame_height > FRAME_W'(MAX_EXTENT)) begin
      cfg_eff.frame_height = FRAME_W'(MAX_EXTENT);
    end
    if ({1'b0, cfg.pad} > (PAD_W+1)'(MAX_PAD)) begin
      cfg_eff.pad = PAD_W'(MAX_PAD);
    end
  end

  // credit count: items in the pipe plus results waiting in the queue
  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] credits;
  logic [CNT_W-1:0] credits_next;

  assign in_ready     = credits < CNT_W'(FIFO_DEPTH);
  assign in_fire      = in_valid && in_ready;
  assign out_fire     = out_valid && out_ready;
  assign credits_next = credits + CNT_W'(in_fire) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits_next;
    end
  end

  // clamp, products and atlas index
  cell_t chain [QUO_W+1];

  spba_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_data (in_data),
    .cfg     (cfg_eff),
    .dout    (chain[0])
  );

  // division chain, one quotient bit per cell for both axes
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    spba_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .frame_w (cfg_eff.frame_width),
      .frame_h (cfg_eff.frame_height),
      .din     (chain[i]),
      .dout    (chain[i+1])
    );
  end

  // final source index: sy * src_width + sx, zeroed for outside coordinates
  cell_t                tail;
  logic [2*SRC_W-1:0]   src_row;
  logic                 fin_valid;
  out_t                 fin_data;

  assign tail    = chain[QUO_W];
  assign src_row = (2*SRC_W)'(tail.y.lo) * (2*SRC_W)'(cfg.src_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.outside) begin
      fin_data.source_index <= '0;
      fin_data.atlas_index  <= '0;
      fin_data.outside      <= 1'b1;
    end else begin
      fin_data.source_index <= src_row[INDEX_W-1:0] + INDEX_W'(tail.x.lo);
      fin_data.atlas_index  <= tail.atlas_index;
      fin_data.outside      <= 1'b0;
    end
  end

  // result queue toward the output channel
  logic q_empty;

  spba_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fin_valid),
    .wr_data (fin_data),
    .rd_en   (out_fire),
    .rd_data (out_data),
    .empty   (q_empty)
  );

  assign out_valid = !q_empty;

`ifndef SYNTHESIS
  // credits never exceed the queue depth, so the queue cannot overflow
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= CNT_W'(FIFO_DEPTH))
    else $error("credit count beyond queue depth");

  // a waiting result always holds a credit
  a_result_has_credit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credits != '0)
    else $error("result present without credit");

  // outside coordinates carry zero indexes
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.outside) |->
      (out_data.source_index == '0 && out_data.atlas_index == '0))
    else $error("outside result with nonzero index");

  // an accepted item reaches the division chain after the front stage registers s1 and s2
  a_pipe_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ##1 chain[0].valid)
    else $error("accepted item lost in front stages");
`endif

endmodule

@@ sim/blit_address_checker.sv @@
// transfer monitor, address predictor and result comparator for the blit address generator
module blit_address_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  spba_pkg::in_t                 in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  spba_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [spba_pkg::REGIDX_W-1:0] cfg_index,
  input  logic [spba_pkg::CFG_W-1:0]    cfg_data,
  output int                            errors,
  output int                            waiting,
  output int                            checked,
  output int                            outside_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import spba_pkg::*;

  cfg_t shadow;
  out_t addr_q[$];

  // clamp to the interior, then nearest-neighbor scale to the source
  function automatic longint unsigned scale_axis(longint unsigned c, longint unsigned pd,
                                                 longint unsigned frame,
                                                 longint unsigned src);
    longint unsigned inner;
    inner = (c < pd) ? 0 : c - pd;
    if (inner > frame - 1) inner = frame - 1;
    return inner * src / frame;
  endfunction

  function automatic out_t map_coord(in_t c);
    longint unsigned fw, fh, pd, col, rw, sx, sy, sidx, aidx;
    out_t r;
    r = '0;
    fw = longint'(shadow.frame_width);
    fh = longint'(shadow.frame_height);
    pd = longint'(shadow.pad);
    if (fw > longint'(MAX_EXTENT)) fw = longint'(MAX_EXTENT);
    if (fh > longint'(MAX_EXTENT)) fh = longint'(MAX_EXTENT);
    if (pd > longint'(MAX_PAD)) pd = longint'(MAX_PAD);
    col = longint'(c.column);
    rw = longint'(c.row);
    if (fw == 0 || fh == 0 || col >= fw + 2 * pd || rw >= fh + 2 * pd) begin
      r.outside = 1'b1;
      return r;
    end
    sx = scale_axis(col, pd, fw, longint'(shadow.src_width));
    sy = scale_axis(rw, pd, fh, longint'(shadow.src_height));
    sidx = sy * longint'(shadow.src_width) + sx;
    aidx = (longint'(shadow.dest_y) + rw) * longint'(shadow.pitch) +
           longint'(shadow.dest_x) + col;
    r.source_index = sidx[INDEX_W-1:0];
    r.atlas_index = aidx[INDEX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      shadow.src_width = SRC_W'(1);
      shadow.src_height = SRC_W'(1);
      shadow.frame_width = FRAME_W'(1);
      shadow.frame_height = FRAME_W'(1);
      shadow.pad = '0;
      shadow.pitch = ATLAS_W'(64);
      shadow.dest_x = '0;
      shadow.dest_y = '0;
      addr_q.delete();
      errors = 0;
      checked = 0;
      outside_seen = 0;
    end else begin
      // predict with the settings in force before any write at this edge
      if (in_valid && in_ready) addr_q.push_back(map_coord(in_data));
      if (out_valid && out_ready) begin
        checked++;
        if (out_data.outside) outside_seen++;
        if (addr_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: src %0d atlas %0d outside %0d",
                     out_data.source_index, out_data.atlas_index, out_data.outside);
        end else begin
          want = addr_q.pop_front();
          if (want.source_index !== out_data.source_index ||
              want.atlas_index !== out_data.atlas_index ||
              want.outside !== out_data.outside) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected src %0d atlas %0d outside %0d,",
                       want.source_index, want.atlas_index, want.outside,
                       " got src %0d atlas %0d outside %0d",
                       out_data.source_index, out_data.atlas_index, out_data.outside);
          end
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SRC_WIDTH:    shadow.src_width = cfg_data[SRC_W-1:0];
          REG_SRC_HEIGHT:   shadow.src_height = cfg_data[SRC_W-1:0];
          REG_FRAME_WIDTH:  shadow.frame_width = cfg_data[FRAME_W-1:0];
          REG_FRAME_HEIGHT: shadow.frame_height = cfg_data[FRAME_W-1:0];
          REG_PAD:          shadow.pad = cfg_data[PAD_W-1:0];
          REG_PITCH:        shadow.pitch = cfg_data[ATLAS_W-1:0];
          REG_DEST_X:       shadow.dest_x = cfg_data[DEST_W-1:0];
          REG_DEST_Y:       shadow.dest_y = cfg_data[DEST_W-1:0];
          default: ;
        endcase
      end
    end
    waiting = addr_q.size();
  end

endmodule

@@ sim/tb_scaled_padded_blit_address_top.sv @@
// testbench top of the blit address generator: stimulus, flow control and verdict
module tb_scaled_padded_blit_address_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spba_pkg::*;

  // long output hold-off, fills the 32-entry result queue and backs up the input
  localparam int HOLD_CYCLES = 300;
  // settle time after the last result, longer than the pipeline depth
  localparam int DRAIN_CYCLES = 40;
  localparam longint TIMEOUT_NS = 4_000_000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_we;
  logic [REGIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  int errors, waiting, checked, outside_seen;
  int settings;
  bit hold_req;
  // stimulus-side copy of the settings, only used to aim coordinates
  cfg_t cur;

  scaled_padded_blit_address_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blit_address_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .waiting      (waiting),
    .checked      (checked),
    .outside_seen (outside_seen)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random ready patterns of random length, plus one long hold-off
  initial begin
    int mode, left;
    out_ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;                               // never stall
          1: out_ready <= ($urandom_range(0, 1) == 1);         // coin flip
          2: out_ready <= ($urandom_range(0, 9) != 0);         // rare stalls
          default: out_ready <= ((left % 3) == 0);             // one in three
        endcase
      end
    end
  end

  function automatic in_t mk(int unsigned col, int unsigned rw);
    in_t c;
    c.column = col[COORD_W-1:0];
    c.row = rw[COORD_W-1:0];
    return c;
  endfunction

  function automatic cfg_t make_cfg(int unsigned sw, int unsigned sh, int unsigned fw,
                                    int unsigned fh, int unsigned pd, int unsigned aw,
                                    int unsigned dx, int unsigned dy);
    cfg_t c;
    c.src_width = sw[SRC_W-1:0];
    c.src_height = sh[SRC_W-1:0];
    c.frame_width = fw[FRAME_W-1:0];
    c.frame_height = fh[FRAME_W-1:0];
    c.pad = pd[PAD_W-1:0];
    c.pitch = aw[ATLAS_W-1:0];
    c.dest_x = dx[DEST_W-1:0];
    c.dest_y = dy[DEST_W-1:0];
    return c;
  endfunction

  // zero, bottom and top of range, all ones, small or anywhere in range
  function automatic int unsigned pick_field(int unsigned w, int unsigned lo,
                                             int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 18) return lo;
    if (r < 28) return hi;
    if (r < 35) return (1 << w) - 1;
    if (r < 65) return $urandom_range(lo, (hi < lo + 64) ? hi : lo + 64);
    return $urandom_range(lo, hi);
  endfunction

  function automatic cfg_t pick_cfg();
    return make_cfg(pick_field(SRC_W, 1, 16384), pick_field(SRC_W, 1, 16384),
                    pick_field(FRAME_W, 1, 4096), pick_field(FRAME_W, 1, 4096),
                    pick_field(PAD_W, 0, 255), pick_field(ATLAS_W, 64, 16384),
                    pick_field(DEST_W, 0, 16383), pick_field(DEST_W, 0, 16383));
  endfunction

  // mostly inside the padded extent, some on its border, some anywhere
  function automatic int unsigned pick_axis(int unsigned ext);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, (1 << COORD_W) - 1);
    if (r < 30) return $urandom_range((ext > 2) ? ext - 2 : 0, ext + 1);
    return $urandom_range(0, (ext > 0) ? ext - 1 : 0);
  endfunction

  function automatic in_t pick_coord();
    int unsigned fw, fh, pd;
    fw = int'(cur.frame_width);
    fh = int'(cur.frame_height);
    pd = int'(cur.pad);
    if (fw > MAX_EXTENT) fw = MAX_EXTENT;
    if (fh > MAX_EXTENT) fh = MAX_EXTENT;
    return mk(pick_axis(fw + 2 * pd), pick_axis(fh + 2 * pd));
  endfunction

  // offer one coordinate and hold it until the transfer; returns on a falling edge
  task automatic send_coord(input in_t c);
    in_data <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // stop offering and wait until every predicted address has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
  endtask

  // only called with nothing in flight
  task automatic apply_config(input cfg_t c);
    write_reg(REG_SRC_WIDTH, c.src_width);
    write_reg(REG_SRC_HEIGHT, c.src_height);
    write_reg(REG_FRAME_WIDTH, CFG_W'(c.frame_width));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(c.frame_height));
    write_reg(REG_PAD, CFG_W'(c.pad));
    write_reg(REG_PITCH, c.pitch);
    write_reg(REG_DEST_X, CFG_W'(c.dest_x));
    write_reg(REG_DEST_Y, CFG_W'(c.dest_y));
    cfg_we <= 1'b0;
    cur = c;
    settings++;
  endtask

  task automatic send_list(input in_t pts[$]);
    foreach (pts[i]) begin
      send_coord(pts[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
    end
  endtask

  // bursts of random length with random gaps, or back to back
  task automatic run_random(input int n, input bit gaps);
    int burst;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      send_coord(pick_coord());
      if (gaps) begin
        burst--;
        if (burst == 0) begin
          idle_gap($urandom_range(1, 12));
          burst = $urandom_range(1, 24);
        end
      end
    end
  endtask

  initial begin
    in_t pts[$];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    settings = 1;
    cur = make_cfg(1, 1, 1, 1, 0, 64, 0, 0);
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: a single interior pixel, anything else is outside
    pts = '{mk(0, 0), mk(1, 0), mk(0, 1)};
    send_list(pts);
    drain();

    // ordinary frame: pad corners, first and last interior pixel, just beyond the edges
    apply_config(make_cfg(100, 60, 40, 30, 3, 512, 10, 20));
    pts = '{mk(0, 0), mk(2, 2), mk(3, 3), mk(42, 32), mk(45, 35), mk(46, 0),
            mk(0, 36), mk(20, 15), mk(1, 34), mk(8191, 0), mk(8191, 8191)};
    send_list(pts);
    drain();

    // all ones: oversized frame saturates, indexes wrap
    apply_config(make_cfg(32767, 32767, 8191, 8191, 255, 32767, 16383, 16383));
    pts = '{mk(0, 0), mk(4605, 4605), mk(4606, 0), mk(2000, 3000), mk(256, 4350),
            mk(8191, 8191)};
    send_list(pts);
    drain();

    // zero frame width: nothing is inside
    apply_config(make_cfg(0, 5, 0, 9, 2, 64, 3, 3));
    pts = '{mk(0, 0), mk(2, 2)};
    send_list(pts);
    drain();

    // zero source width and zero atlas pitch, no padding
    apply_config(make_cfg(0, 7, 7, 9, 0, 0, 100, 200));
    pts = '{mk(0, 0), mk(6, 8), mk(7, 0)};
    send_list(pts);
    drain();

    // bottom of every range
    apply_config(make_cfg(1, 1, 1, 1, 0, 64, 0, 0));
    run_random(60, 1'b1);
    drain();

    // top of every range, with a full pause halfway through
    apply_config(make_cfg(16384, 16384, 4096, 4096, 255, 16384, 16383, 16383));
    run_random(30, 1'b1);
    drain();
    run_random(30, 1'b1);
    drain();

    for (int p = 0; p < 5; p++) begin
      apply_config(pick_cfg());
      if (p == 1) begin
        // receiver holds off while the sender keeps pushing back to back
        hold_req = 1'b1;
        run_random(66, 1'b0);
      end else begin
        run_random(66, 1'b1);
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("checked %0d addresses under %0d register settings, %0d outside the frame",
             checked, settings, outside_seen);
    $display("failures: %0d, predictions left: %0d", errors, waiting);
    if (errors == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
